### src/stop_and_wait_arq_sender_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stop-and-wait ARQ sender
// Shared shorthand for clocked properties with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_SENDER_UNIT_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define SAWARQ_ASSERT_NOW(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SAWARQ_ASSERT_NEXT(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

### src/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender package
// Sizes, protocol bytes, item kinds and the types shared between the parts.
// ----------------------------------------------------------------------------
package sawarq_pkg;

    localparam int MSG_DEPTH  = 256;
    localparam int IDX_W      = $clog2(MSG_DEPTH);
    localparam int PTR_W      = $clog2(MSG_DEPTH + 1);
    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h88;
    localparam logic [BYTE_W-1:0] NAK_BYTE = 8'h55;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_CTRL = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PARITY = 2'd1,
        PH_SEQ    = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } frame_cmd_t;

    typedef struct packed {
        logic             empty;
        logic [LVL_W-1:0] level;
    } fifo_status_t;

endpackage

### src/sawarq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sawarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/sawarq_front.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender front end
// Accepts items, keeps the protocol state, stores message bytes and issues
// one frame command (index and data byte) per frame to be sent.
// ----------------------------------------------------------------------------
module sawarq_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [sawarq_pkg::BYTE_W-1:0]    byte_value,
    input  logic                             is_last_byte,
    input  sawarq_pkg::fifo_status_t         fifo_status,
    output logic                             push,
    output sawarq_pkg::frame_cmd_t           push_cmd
);
    import sawarq_pkg::*;

    logic [PTR_W-1:0]  load_ptr_reg,  load_ptr_next;
    logic [IDX_W-1:0]  last_idx_reg,  last_idx_next;
    logic [IDX_W-1:0]  cur_idx_reg,   cur_idx_next;
    logic              awaiting_reg,  awaiting_next;

    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_byp_reg;
    logic [BYTE_W-1:0] s1_bdata_reg;

    logic              accept;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  slot;
    logic              emit;
    logic [IDX_W-1:0]  emit_idx;
    logic [BYTE_W-1:0] rd_data;

    // Room is reserved for the frame still in the read stage.
    assign in_stall = ({1'b0, fifo_status.level} + (LVL_W+1)'(s1_valid_reg))
                      >= (LVL_W+1)'(FIFO_DEPTH);
    assign accept   = in_valid && !in_stall;
    assign wr_addr  = load_ptr_reg[IDX_W-1:0];

    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        last_idx_next = last_idx_reg;
        cur_idx_next  = cur_idx_reg;
        awaiting_next = awaiting_reg;
        wr_en         = 1'b0;
        slot          = IDX_W'(MSG_DEPTH - 1);
        emit          = 1'b0;
        emit_idx      = cur_idx_reg;
        if (accept)
        begin
            case (kind)
                KIND_LOAD:
                begin
                    if (load_ptr_reg < PTR_W'(MSG_DEPTH))
                    begin
                        wr_en         = 1'b1;
                        slot          = wr_addr;
                        load_ptr_next = load_ptr_reg + PTR_W'(1);
                    end
                    if (is_last_byte)
                    begin
                        last_idx_next = slot;
                        cur_idx_next  = '0;
                        load_ptr_next = '0;
                        awaiting_next = 1'b1;
                        emit          = 1'b1;
                        emit_idx      = '0;
                    end
                end
                KIND_CTRL:
                begin
                    awaiting_next = 1'b0;
                    if (byte_value == ACK_BYTE)
                    begin
                        if (cur_idx_reg != last_idx_reg)
                        begin
                            cur_idx_next  = cur_idx_reg + IDX_W'(1);
                            awaiting_next = 1'b1;
                            emit          = 1'b1;
                            emit_idx      = cur_idx_reg + IDX_W'(1);
                        end
                    end
                    else if (byte_value == NAK_BYTE)
                    begin
                        awaiting_next = 1'b1;
                        emit          = 1'b1;
                    end
                end
                KIND_TICK:
                begin
                    emit = awaiting_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            last_idx_reg <= '0;
            cur_idx_reg  <= '0;
            awaiting_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            load_ptr_reg <= load_ptr_next;
            last_idx_reg <= last_idx_next;
            cur_idx_reg  <= cur_idx_next;
            awaiting_reg <= awaiting_next;
            s1_valid_reg <= emit;
        end
    end

    // A byte written in the same cycle as the frame read is forwarded.
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= emit_idx;
        s1_byp_reg   <= wr_en && (wr_addr == emit_idx);
        s1_bdata_reg <= byte_value;
    end

    sawarq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MSG_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_value),
        .rd_en   (emit),
        .rd_addr (emit_idx),
        .rd_data (rd_data)
    );

    assign push          = s1_valid_reg;
    assign push_cmd.idx  = s1_idx_reg;
    assign push_cmd.data = s1_byp_reg ? s1_bdata_reg : rd_data;

endmodule

### src/sawarq_fifo.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender command queue
// Short queue of frame commands between the front and back ends.
// ----------------------------------------------------------------------------
module sawarq_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sawarq_pkg::frame_cmd_t     push_cmd,
    input  logic                       pop,
    output sawarq_pkg::frame_cmd_t     head,
    output sawarq_pkg::fifo_status_t   status
);
    import sawarq_pkg::*;

    frame_cmd_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]      level_reg,  level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = (level_reg == '0);

endmodule

### src/sawarq_back.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender back end
// Serializes each queued frame command into header, parity, sequence and
// data bytes through a registered output word.
// ----------------------------------------------------------------------------
module sawarq_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sawarq_pkg::frame_cmd_t           head,
    input  sawarq_pkg::fifo_status_t         fifo_status,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sawarq_pkg::BYTE_W-1:0]    out_byte,
    output logic                             frame_end
);
    import sawarq_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              frame_end_reg;
    logic              load_en;
    logic              advance;
    logic [BYTE_W-1:0] byte_sel;

    assign load_en = !out_valid_reg || !out_stall;
    assign advance = load_en && !fifo_status.empty;

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_HEADER: phase_next = PH_PARITY;
                PH_PARITY: phase_next = PH_SEQ;
                PH_SEQ:    phase_next = PH_DATA;
                PH_DATA:   phase_next = PH_HEADER;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_HEADER: byte_sel = HDR_BYTE;
            PH_PARITY: byte_sel = BYTE_W'(^head.data);
            PH_SEQ:    byte_sel = BYTE_W'(head.idx);
            PH_DATA:   byte_sel = head.data;
            default:   byte_sel = HDR_BYTE;
        endcase
        pop = advance && (phase_reg == PH_DATA);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load_en)
            begin
                out_valid_reg <= !fifo_status.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= byte_sel;
            frame_end_reg <= (phase_reg == PH_DATA);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

endmodule

### src/stop_and_wait_arq_sender_unit.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender.
// Input channel (in_valid/in_stall): kind selects a message byte load, a
// received control byte (ACK 0x88, NAK 0x55, anything else), or a timer tick.
// Output channel (out_valid/out_stall): one frame byte per word; a frame is
// header 0x7E, parity, sequence number and data byte, with frame_end on the
// data byte.
// The header of a frame passes the read stage, the command queue and the
// output register after the item that causes it is accepted; the other three
// bytes follow it without gaps when the receiver does not stall.
// Throughput: items that cause no frame are taken one per cycle while
// in_stall is low; frames go out at one byte per cycle while the receiver
// does not stall. A two-entry command queue between the front end and the
// serializer lets a new item be accepted while a frame is going out.
// Reset clears the protocol state and empties the queue; the message store
// holds no defined contents until loaded.
// When the receiver stalls, the current word holds; once the queue and the
// read stage together hold two frames, in_stall rises until one is sent.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [sawarq_pkg::BYTE_W-1:0] byte_value,
    input  logic                          is_last_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sawarq_pkg::BYTE_W-1:0] out_byte,
    output logic                          frame_end
);
    import sawarq_pkg::*;

    logic         push;
    logic         pop;
    frame_cmd_t   push_cmd;
    frame_cmd_t   head;
    fifo_status_t fifo_status;

    sawarq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .byte_value   (byte_value),
        .is_last_byte (is_last_byte),
        .fifo_status  (fifo_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    sawarq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (fifo_status)
    );

    sawarq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_end   (frame_end)
    );

endmodule

### src/sawarq_checker.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender port checker
// Watches the top-level ports for frame ordering and word stability.
// ----------------------------------------------------------------------------
`include "stop_and_wait_arq_sender_unit_macros.svh"

module sawarq_assertions (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    kind,
    input logic [sawarq_pkg::BYTE_W-1:0] byte_value,
    input logic                          is_last_byte,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sawarq_pkg::BYTE_W-1:0] out_byte,
    input logic                          frame_end
);
    import sawarq_pkg::*;

    logic              out_wait;
    logic              out_take;
    logic              out_head;
    logic              in_wait;
    logic [BYTE_W:0]   out_word;
    logic [BYTE_W+2:0] in_word;

    assign out_wait = out_valid && out_stall;
    assign out_take = out_valid && !out_stall;
    assign out_head = (out_byte == HDR_BYTE) && !frame_end;
    assign in_wait  = in_valid && in_stall;
    assign out_word = {out_byte, frame_end};
    assign in_word  = {kind, byte_value, is_last_byte};

    // A stalled output word stays on the port unchanged.
    `SAWARQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_word), "word moved")

    // A stalled input word is held by its source until it is taken.
    `SAWARQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_word), "input moved")

    // Inside a frame the next byte is ready right after one is taken.
    `SAWARQ_ASSERT_NEXT(a_frame_gapless, clk, rst_n, out_take && !frame_end, out_valid, "frame gap")

    // The word after a frame's last byte, if any, opens a new frame.
    `SAWARQ_ASSERT_NEXT(a_header_next, clk, rst_n, out_take && frame_end, !out_valid || out_head, "no header")

endmodule

bind stop_and_wait_arq_sender_unit sawarq_assertions u_checker (.*);
